FILE: rtl/adsl_pkg.sv
package adsl_pkg;

	localparam int DATA_W  = 32;
	localparam int FRAC_W  = 16;
	localparam int DT_FRAC = 24;
	localparam int REG_W   = 31;

	localparam logic [REG_W-1:0] SMAX      = {REG_W{1'b1}};
	localparam logic [REG_W-1:0] REG_RESET = 31'd65536;

	localparam logic [2:0] REG_ACCEL_FWD   = 3'd0;
	localparam logic [2:0] REG_DECEL_FWD   = 3'd1;
	localparam logic [2:0] REG_ACCEL_BWD   = 3'd2;
	localparam logic [2:0] REG_DECEL_BWD   = 3'd3;
	localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
	localparam logic [2:0] REG_DAMPING     = 3'd5;
	localparam logic [2:0] REG_POS_GAIN    = 3'd6;
	localparam logic [2:0] REG_ENABLED     = 3'd7;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_D1,
		ST_SQ,
		ST_MK,
		ST_DK1,
		ST_DK2,
		ST_ML,
		ST_MC,
		ST_MU,
		ST_MD,
		ST_FIN1,
		ST_FIN2,
		ST_FIN3,
		ST_PUSH
	} state_t;

endpackage

FILE: rtl/adsl_serial_alu.sv
// Shared bit-serial unit: shift-add multiply, restoring divide and digit-by-digit root.
module adsl_serial_alu
	import adsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  alu_op_t     op,
	input  logic [95:0] opa,
	input  logic [32:0] opb,
	output logic        done,
	output logic [95:0] result
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	alu_op_t     op_q;
	logic [95:0] w_q;
	logic [63:0] a_q;
	logic [32:0] b_q;
	logic [33:0] r_q;
	logic [31:0] root_q;

	logic [64:0] sum;
	logic [33:0] r_sh;
	logic        ge_div;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge_sq;

	always_comb begin
		sum    = {1'b0, w_q[95:32]} + (w_q[0] ? {1'b0, a_q} : 65'd0);
		r_sh   = {r_q[32:0], w_q[95]};
		ge_div = r_sh >= {1'b0, b_q};
		rem_sh = {r_q, w_q[95:94]};
		trial  = {2'b00, root_q, 2'b01};
		ge_sq  = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= op;
				cnt_q  <= (op == ALU_DIV) ? 7'd95 : 7'd31;
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= opa[63:0];
			b_q    <= opb;
			r_q    <= '0;
			root_q <= '0;
			unique case (op)
				ALU_MUL:  w_q <= {64'd0, opb[31:0]};
				ALU_DIV:  w_q <= opa;
				ALU_SQRT: w_q <= {opa[63:0], 32'd0};
				default:  w_q <= opa;
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					w_q <= {sum, w_q[31:1]};
				end
				ALU_DIV: begin
					r_q <= ge_div ? r_sh - {1'b0, b_q} : r_sh;
					w_q <= {w_q[94:0], ge_div};
				end
				ALU_SQRT: begin
					r_q    <= ge_sq ? 34'(rem_sh - trial) : rem_sh[33:0];
					root_q <= {root_q[30:0], ge_sq};
					w_q    <= {w_q[93:0], 2'b00};
				end
				default: begin
					w_q <= w_q;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = (op_q == ALU_SQRT) ? {64'd0, root_q} : w_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("serial unit started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("done without a preceding operation");
	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && cnt_q == 7'd0) |=> done_q)
		else $error("operation ended without done");

endmodule

FILE: rtl/accel_decel_speed_limiter.sv
// Acceleration and deceleration speed limiter, Q16.16 for speeds and limits, with the
// time step as an unsigned Q0.24 fraction. Each input word (time step, target,
// measured speed, goal, position error) yields one limited speed word. All
// multiplies, divides and the square root run through one shared bit-serial unit.
// A word whose goal equals the previous goal needs one multiply, two divides, four
// multiplies, the clamping states FIN1 to FIN3 and the hand-over state PUSH; a
// changed goal adds three multiplies, one divide and one root before these. With
// the limiter disabled the target goes straight to the hand-over state and into
// the output register once that register is free; the next word is taken after that.
// Only one word is processed at a time; the output register lets a new word be
// accepted while the previous result still waits. Configuration writes are taken
// at any edge with cfg_we high and must only be made while the block is idle.
module accel_decel_speed_limiter
	import adsl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [REG_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        step_time,
	input  logic signed [31:0] target_speed,
	input  logic signed [31:0] measured_speed,
	input  logic signed [31:0] goal_position,
	input  logic signed [31:0] error_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] limited_speed
);

	// Configuration registers.
	logic [REG_W-1:0] accel_fwd_q, decel_fwd_q, accel_bwd_q, decel_bwd_q;
	logic [REG_W-1:0] lim_q, damping_q, pos_gain_q;
	logic             enabled_q;

	// Persistent state.
	logic signed [31:0] last_goal_q;
	logic signed [31:0] last_out_q;
	logic [REG_W-1:0]   dss_q;

	state_t state_q, state_d;
	logic   start_q;
	logic   out_valid_q;
	logic signed [31:0] out_q;

	// Per-word working registers.
	logic [23:0]        dt_q;
	logic signed [31:0] tgt_q;
	logic [31:0]        err_mag_q, meas_mag_q;
	logic               fwd_q;
	logic [REG_W-1:0]   acc_q, dec_q;
	logic [63:0]        s_q;
	logic               num_zero_q;
	logic [REG_W-1:0]   k1_q, k2_q, lo2_q, dup_q, ddown_q;
	logic signed [31:0] comp_q;
	logic signed [33:0] res_q;

	alu_op_t     alu_op;
	logic [95:0] alu_a;
	logic [32:0] alu_b;
	logic        alu_done;
	logic [95:0] alu_res;

	logic        accept;
	logic        push;
	logic [32:0] den;
	logic        k_neg;
	logic [REG_W-1:0] k_diff;

	adsl_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.op     (alu_op),
		.opa    (alu_a),
		.opb    (alu_b),
		.done   (alu_done),
		.result (alu_res)
	);

	function automatic logic [REG_W-1:0] cap_q(input logic [95:0] q);
		return (q[95:31] != '0) ? SMAX : q[30:0];
	endfunction

	function automatic logic [31:0] smag(input logic signed [31:0] x);
		return x[31] ? 32'd0 - x : x;
	endfunction

	assign accept = in_valid && in_ready;
	assign push   = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign den    = {2'b00, acc_q} + {2'b00, dec_q};
	assign k_neg  = k1_q < k2_q;
	assign k_diff = k_neg ? k2_q - k1_q : k1_q - k2_q;

	// Next state and operand selection.
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		alu_op   = ALU_MUL;
		alu_a    = '0;
		alu_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!enabled_q)
						state_d = ST_PUSH;
					else if (goal_position != last_goal_q)
						state_d = ST_M1;
					else
						state_d = ST_MK;
				end
			end
			ST_M1: begin
				alu_a = {64'd0, err_mag_q};
				alu_b = {2'b00, acc_q};
				if (alu_done) state_d = ST_M2;
			end
			ST_M2: begin
				alu_a = {64'd0, meas_mag_q};
				alu_b = {1'b0, meas_mag_q};
				if (alu_done) state_d = ST_M3;
			end
			ST_M3: begin
				alu_a = {32'd0, s_q};
				alu_b = {2'b00, dec_q};
				if (alu_done) state_d = ST_D1;
			end
			ST_D1: begin
				alu_op = ALU_DIV;
				alu_a  = alu_res;
				alu_b  = den;
				if (alu_done) state_d = ST_SQ;
			end
			ST_SQ: begin
				alu_op = ALU_SQRT;
				alu_a  = {32'd0, s_q};
				if (alu_done) state_d = ST_MK;
			end
			ST_MK: begin
				alu_a = {65'd0, pos_gain_q};
				alu_b = {2'b00, damping_q};
				if (alu_done) state_d = ST_DK1;
			end
			ST_DK1: begin
				alu_op = ALU_DIV;
				alu_a  = alu_res;
				alu_b  = {1'b0, dec_q, 1'b0};
				if (alu_done) state_d = ST_DK2;
			end
			ST_DK2: begin
				alu_op = ALU_DIV;
				alu_a  = 96'd1 << (2 * FRAC_W);
				alu_b  = {2'b00, dss_q};
				if (alu_done) state_d = ST_ML;
			end
			ST_ML: begin
				alu_a = {64'd0, smag(last_out_q)};
				alu_b = {1'b0, smag(last_out_q)};
				if (alu_done) state_d = ST_MC;
			end
			ST_MC: begin
				alu_a = {65'd0, lo2_q};
				alu_b = {2'b00, k_diff};
				if (alu_done) state_d = ST_MU;
			end
			ST_MU: begin
				alu_a = {65'd0, fwd_q ? acc_q : dec_q};
				alu_b = {9'd0, dt_q};
				if (alu_done) state_d = ST_MD;
			end
			ST_MD: begin
				alu_a = {65'd0, fwd_q ? dec_q : acc_q};
				alu_b = {9'd0, dt_q};
				if (alu_done) state_d = ST_FIN1;
			end
			ST_FIN1: state_d = ST_FIN2;
			ST_FIN2: state_d = ST_FIN3;
			ST_FIN3: state_d = ST_PUSH;
			ST_PUSH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= (state_d != state_q) && (state_d != ST_IDLE) &&
				(state_d != ST_FIN1) && (state_d != ST_FIN2) &&
				(state_d != ST_FIN3) && (state_d != ST_PUSH);
		end
	end

	// Compensation term from the multiply in ST_MC, with the direction applied.
	logic [31:0]        cm;
	logic               comp_neg;
	logic signed [31:0] comp_d;

	always_comb begin
		if (k_neg)
			cm = ((alu_res[95:48] != '0) || (alu_res[47] && alu_res[46:16] != '0)) ?
				32'h8000_0000 : alu_res[47:16];
		else
			cm = (alu_res[95:47] != '0) ? {1'b0, SMAX} : alu_res[47:16];
		comp_neg = k_neg ^ !fwd_q;
		if (comp_neg)
			comp_d = 32'sd0 - $signed(cm);
		else
			comp_d = (cm[31]) ? $signed({1'b0, SMAX}) : $signed(cm);
	end

	// Clamping arithmetic.
	logic signed [33:0] diff, lim_s, up_s, low_s, r1, r2, r3;

	always_comb begin
		lim_s = {3'b000, lim_q};
		diff  = 34'(tgt_q) - 34'(comp_q);
		up_s  = 34'(last_out_q) + {3'b000, dup_q};
		low_s = 34'(last_out_q) - {3'b000, ddown_q};
		r1    = (res_q > lim_s) ? lim_s : res_q;
		r2    = (r1 < -lim_s) ? -lim_s : r1;
		r3    = r2;
		if (tgt_q > 0 && r2 > 34'(tgt_q))
			r3 = 34'(tgt_q);
		if (tgt_q < 0 && r2 < 34'(tgt_q))
			r3 = 34'(tgt_q);
	end

	// Configuration, persistent state and the output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_fwd_q <= REG_RESET;
			decel_fwd_q <= REG_RESET;
			accel_bwd_q <= REG_RESET;
			decel_bwd_q <= REG_RESET;
			lim_q       <= REG_RESET;
			damping_q   <= REG_RESET;
			pos_gain_q  <= REG_RESET;
			enabled_q   <= 1'b1;
			last_goal_q <= '0;
			last_out_q  <= '0;
			dss_q       <= REG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACCEL_FWD:   accel_fwd_q <= cfg_data;
					REG_DECEL_FWD:   decel_fwd_q <= cfg_data;
					REG_ACCEL_BWD:   accel_bwd_q <= cfg_data;
					REG_DECEL_BWD:   decel_bwd_q <= cfg_data;
					REG_SPEED_LIMIT: lim_q       <= cfg_data;
					REG_DAMPING:     damping_q   <= cfg_data;
					REG_POS_GAIN:    pos_gain_q  <= cfg_data;
					REG_ENABLED: begin
						// Re-enabling starts from a clean state.
						if (!enabled_q && cfg_data[0]) begin
							last_goal_q <= '0;
							last_out_q  <= '0;
							dss_q       <= lim_q;
						end
						enabled_q <= cfg_data[0];
					end
					default: enabled_q <= enabled_q;
				endcase
			end
			if (accept && enabled_q && goal_position != last_goal_q)
				last_goal_q <= goal_position;
			if (state_q == ST_SQ && alu_done)
				dss_q <= (alu_res[31:0] > {1'b0, lim_q}) ? lim_q : alu_res[30:0];
			if (state_q == ST_FIN3)
				last_out_q <= r3[31:0];
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Working registers of the word in flight.
	always_ff @(posedge clk) begin
		if (accept) begin
			dt_q       <= step_time;
			tgt_q      <= target_speed;
			err_mag_q  <= smag(error_position);
			meas_mag_q <= smag(measured_speed);
			fwd_q      <= !error_position[31];
			acc_q      <= error_position[31] ? accel_bwd_q : accel_fwd_q;
			dec_q      <= error_position[31] ? decel_bwd_q : decel_fwd_q;
		end
		if (alu_done) begin
			case (state_q)
				ST_M1:  s_q <= {alu_res[62:0], 1'b0};
				ST_M2:  s_q <= s_q + alu_res[63:0];
				ST_D1:  s_q <= (den == '0) ? 64'd0 : alu_res[63:0];
				ST_MK:  num_zero_q <= (alu_res[61:0] == '0);
				ST_DK1: k1_q <= num_zero_q ? '0 : cap_q(alu_res);
				ST_DK2: k2_q <= cap_q(alu_res);
				ST_ML:  lo2_q <= (alu_res[95:47] != '0) ? SMAX : alu_res[46:16];
				ST_MC:  comp_q <= comp_d;
				ST_MU:  dup_q <= alu_res[54:24];
				ST_MD:  ddown_q <= alu_res[54:24];
				default: s_q <= s_q;
			endcase
		end
		case (state_q)
			ST_FIN1: begin
				if (diff > 34'sh0_7FFF_FFFF)
					res_q <= 34'sh0_7FFF_FFFF;
				else if (diff < -34'sh0_8000_0000)
					res_q <= -34'sh0_8000_0000;
				else
					res_q <= diff;
			end
			ST_FIN2: begin
				if (res_q > up_s)
					res_q <= up_s;
				else if (res_q < low_s)
					res_q <= low_s;
			end
			ST_FIN3: res_q <= r3;
			default: res_q <= accept ? 34'(target_speed) : res_q;
		endcase
		if (push)
			out_q <= res_q[31:0];
	end

	assign out_valid     = out_valid_q;
	assign limited_speed = out_q;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Testbench for the acceleration and deceleration speed limiter.
// Random words are driven through a valid/ready channel in bursts with random gaps.
// A local model works out the limited speed for every accepted word.
// A monitor compares each output word with the oldest expected speed.
// Configuration is rewritten between phases, and only once the block has gone quiet.
module tb
	import adsl_pkg::*;
();

	typedef struct packed {
		logic [23:0]        dt;
		logic signed [31:0] tgt;
		logic signed [31:0] meas;
		logic signed [31:0] goal;
		logic signed [31:0] err;
	} word_t;

	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [REG_W-1:0]   cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [23:0]        step_time;
	logic signed [31:0] target_speed;
	logic signed [31:0] measured_speed;
	logic signed [31:0] goal_position;
	logic signed [31:0] error_position;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] limited_speed;

	accel_decel_speed_limiter DUT (.*);

	// The limiter's registers and state, as the model sees them.
	longint unsigned lim_reg [8];
	longint last_goal_m, last_out_m, dstart_m;

	word_t           pending_words [$];
	logic [31:0]     expected_speeds [$];
	int              fails;
	bit              hold_off_rx;
	bit              hold_done;
	int              hold_left;
	int              gap_left, burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tb failed");
		$finish;
	end

	function automatic longint sat32(input longint x);
		if (x > QMAX) return QMAX;
		if (x < QMIN) return QMIN;
		return x;
	endfunction

	// Fixed-point product, truncated toward zero, then saturated.
	function automatic longint qmul(input longint a, input longint b);
		logic [127:0] p;
		logic [127:0] lim;
		bit neg;
		longint unsigned ua, ub;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = (128'(ua) * 128'(ub)) >> FRAC_W;
		lim = neg ? 128'd2147483648 : 128'd2147483647;
		if (p > lim) p = lim;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint unsigned floor_root(input logic [127:0] n);
		logic [127:0] r, b;
		r = 0;
		b = 128'd1 << 126;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[63:0];
	endfunction

	function automatic void write_reg(input int idx, input longint unsigned v);
		if (idx == REG_ENABLED) begin
			v = v & 1;
			if (lim_reg[REG_ENABLED] == 0 && v == 1) begin
				last_goal_m = 0;
				last_out_m = 0;
				dstart_m = lim_reg[REG_SPEED_LIMIT];
			end
		end
		lim_reg[idx] = v;
	endfunction

	// Works out the limited speed for one word and moves the state on.
	function automatic logic [31:0] limit_speed(input word_t w);
		bit fwd;
		longint unsigned acc, dec, num, t;
		logic [127:0] s, den, q;
		longint lim, k1, k2, comp, res, up, down, tg;
		if (lim_reg[REG_ENABLED] == 0) return w.tgt;
		tg = w.tgt;
		lim = lim_reg[REG_SPEED_LIMIT];
		fwd = w.err >= 0;
		acc = fwd ? lim_reg[REG_ACCEL_FWD] : lim_reg[REG_ACCEL_BWD];
		dec = fwd ? lim_reg[REG_DECEL_FWD] : lim_reg[REG_DECEL_BWD];
		if (longint'(w.goal) != last_goal_m) begin
			last_goal_m = w.goal;
			s = 128'(2) * acc * 128'(w.err < 0 ? -longint'(w.err) : longint'(w.err))
				+ 128'(w.meas < 0 ? -longint'(w.meas) : longint'(w.meas))
				* 128'(w.meas < 0 ? -longint'(w.meas) : longint'(w.meas));
			den = acc + dec;
			q = (den != 0) ? (s * dec) / den : 0;
			t = floor_root(q);
			dstart_m = (t > lim) ? lim : longint'(t);
		end
		num = lim_reg[REG_POS_GAIN] * lim_reg[REG_DAMPING];
		if (dec == 0) t = (num != 0) ? QMAX : 0;
		else t = num / (2 * dec);
		k1 = (t > QMAX) ? QMAX : longint'(t);
		if (dstart_m <= 0) t = QMAX;
		else t = (64'd1 << (2 * FRAC_W)) / dstart_m;
		k2 = (t > QMAX) ? QMAX : longint'(t);
		comp = qmul(k1 - k2, qmul(last_out_m, last_out_m));
		if (!fwd) comp = sat32(-comp);
		res = sat32(tg - comp);
		up = ((fwd ? acc : dec) * w.dt) >> DT_FRAC;
		down = ((fwd ? dec : acc) * w.dt) >> DT_FRAC;
		if (res > last_out_m + up) res = last_out_m + up;
		if (res < last_out_m - down) res = last_out_m - down;
		if (res > lim) res = lim;
		if (res < -lim) res = -lim;
		if (tg > 0 && res > tg) res = tg;
		if (tg < 0 && res < tg) res = tg;
		last_out_m = res;
		return res[31:0];
	endfunction

	function automatic logic [31:0] rand_signed();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic word_t rand_word(input logic signed [31:0] goal);
		word_t w;
		w.dt = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h4000));
		if ($urandom_range(0, 15) == 0) w.dt = 24'hffffff;
		w.tgt = rand_signed();
		w.meas = rand_signed();
		w.goal = goal;
		w.err = rand_signed();
		return w;
	endfunction

	// The config port is driven from the stimulus process, only while the block is quiet.
	task automatic cfg_write(input logic [2:0] idx, input longint unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[REG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		write_reg(int'(idx), 64'(v[REG_W-1:0]));
	endtask

	task automatic wait_quiet();
		while (pending_words.size() != 0 || expected_speeds.size() != 0 || in_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic longint unsigned rand_reg(input bit may_be_zero);
		case ($urandom_range(0, 5))
			0: return may_be_zero ? 0 : 1;
			1: return 31'h7fffffff;
			2: return $urandom_range(1, 32'h0004_0000);
			3: return $urandom_range(1, 32'h0100_0000);
			default: return $urandom & 32'h7fffffff;
		endcase
	endfunction

	// Driver: the sender runs in bursts of random length with random gaps in between.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_speeds.push_back(limit_speed({step_time, target_speed,
					measured_speed, goal_position, error_position}));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					word_t w;
					w = pending_words.pop_front();
					in_valid <= 1'b1;
					step_time <= w.dt;
					target_speed <= w.tgt;
					measured_speed <= w.meas;
					goal_position <= w.goal;
					error_position <= w.err;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 700);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: the receiver stalls on a pattern of its own; the long hold-off is
	// counted here so that the block fills and holds its input back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_speeds.size() == 0) begin
					$error("limited_speed: no word expected, actual %0d", limited_speed);
					fails++;
				end else begin
					logic [31:0] e;
					e = expected_speeds.pop_front();
					if (e !== limited_speed) begin
						$error("limited_speed: expected %0d, actual %0d",
							$signed(e), limited_speed);
						fails++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_off_rx && !hold_done) begin
				hold_left <= 6000;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
			end
		end
	end

	initial begin
		word_t w;
		logic signed [31:0] g;
		fails = 0;
		hold_off_rx = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACCEL_FWD;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		step_time = '0;
		target_speed = '0;
		measured_speed = '0;
		goal_position = '0;
		error_position = '0;
		for (int i = 0; i < 8; i++) lim_reg[i] = 65536;
		lim_reg[REG_ENABLED] = 1;
		last_goal_m = 0;
		last_out_m = 0;
		dstart_m = 65536;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset settings: field extremes, both directions, a zero
		// error, a zero time step, a held goal and a zero deceleration-time speed.
		pending_words.push_back('{24'd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0});
		pending_words.push_back('{24'hffffff, 32'h7fffffff, 32'h7fffffff, 32'sd5, 32'h7fffffff});
		pending_words.push_back('{24'hffffff, 32'h80000000, 32'h80000000, 32'sd6, 32'h80000000});
		pending_words.push_back('{24'h800000, -32'sd65536, 32'sd0, 32'sd7, -32'sd1});
		pending_words.push_back('{24'h800000, 32'sd100000, 32'sd0, 32'sd7, 32'sd0});
		pending_words.push_back('{24'd0, 32'sd100000, 32'sd0, 32'sd8, 32'sd0});
		pending_words.push_back('{24'h100000, 32'sd3000, 32'sd0, 32'sd8, 32'sd1});
		wait_quiet();

		// Disabled pass-through, then the re-enable that clears the state.
		cfg_write(REG_ENABLED, 0);
		pending_words.push_back('{24'h123456, 32'h80000000, 32'sd1, 32'sd99, 32'sd1});
		pending_words.push_back('{24'h0, 32'h7fffffff, 32'sd1, 32'sd98, -32'sd1});
		wait_quiet();
		cfg_write(REG_ENABLED, 1);
		// Zero deceleration and backward acceleration registers, then zero gain registers.
		cfg_write(REG_DECEL_FWD, 0);
		cfg_write(REG_ACCEL_BWD, 0);
		cfg_write(REG_DECEL_BWD, 0);
		pending_words.push_back('{24'hffffff, 32'sd200000, 32'sd70000, 32'sd11, 32'sd3});
		pending_words.push_back('{24'hffffff, -32'sd200000, 32'sd0, 32'sd12, -32'sd3});
		wait_quiet();
		cfg_write(REG_POS_GAIN, 0);
		cfg_write(REG_DAMPING, 0);
		cfg_write(REG_SPEED_LIMIT, 31'h7fffffff);
		cfg_write(REG_ACCEL_FWD, 31'h7fffffff);
		pending_words.push_back('{24'hffffff, 32'h7fffffff, 32'h7fffffff, 32'sd13, 32'h7fffffff});
		pending_words.push_back('{24'hffffff, 32'h80000000, 32'h7fffffff, 32'sd13, 32'sd4});
		wait_quiet();

		// Random phases, each under fresh settings; the goal is mostly held for a
		// run of words so that the slew and compensation path sees long sequences.
		for (int ph = 0; ph < 20; ph++) begin
			for (int r = 0; r < 7; r++) cfg_write(3'(r), rand_reg(r != 4 && (r == 5 || r == 6
				|| $urandom_range(0, 7) == 0)));
			if (ph % 5 == 4) begin
				cfg_write(REG_ENABLED, 0);
				cfg_write(REG_ENABLED, ($urandom_range(0, 2) != 0));
			end else if (lim_reg[REG_ENABLED] == 0) begin
				cfg_write(REG_ENABLED, 1);
			end
			if (ph == 3) hold_off_rx = 1'b1;
			g = $urandom;
			for (int k = 0; k < 82; k++) begin
				if ($urandom_range(0, 5) == 0) g = rand_signed();
				w = rand_word(g);
				pending_words.push_back(w);
			end
			wait_quiet();
		end

		repeat (2000) @(posedge clk);
		if (fails == 0 && expected_speeds.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/adsl_pkg.sv
rtl/adsl_serial_alu.sv
rtl/accel_decel_speed_limiter.sv
verif/tb.sv
